// ----- rtl/hkt_pkg.sv -----
// ----------------------------------------------------------------------------
// hkt_pkg
// Types, constants and the key-list membership test shared by the
// keyboard last-key tracker modules.
// ----------------------------------------------------------------------------
package hkt_pkg;

	localparam int KEY_W       = 8;
	localparam int MAX_SLOTS   = 6;
	localparam int MOD_BITS    = 8;
	localparam int LIST_LEN    = MOD_BITS + MAX_SLOTS;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [KEY_W-1:0] KBD_REPORT_TYPE = 8'h06;
	localparam logic [KEY_W-1:0] MOD_KEY_FIRST   = 8'hE0;
	localparam logic [KEY_W-1:0] MOD_KEY_LAST    = 8'hE7;
	localparam logic [KEY_W-1:0] NO_KEY          = 8'h00;
	localparam logic [4:0]       HELD_COUNT_MAX  = 5'd31;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [MAX_SLOTS-1:0][KEY_W-1:0] slot_vec_t;

	typedef struct packed {
		logic [7:0] dev_type;
		logic [7:0] modifiers;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic [7:0] top_key;
		logic [4:0] held_count;
		logic       report_used;
	} result_t;

	// classified report handed from the front to the back
	typedef struct packed {
		logic                used;
		logic [7:0]          modifiers;
		slot_vec_t           slots;
		logic [LIST_LEN-1:0] push_mask;
	} job_t;

	function automatic logic key_in_list(input key_t key, input logic [7:0] mods,
			input slot_vec_t slots);
		logic hit;
		hit = 1'b0;
		if (key inside {[MOD_KEY_FIRST:MOD_KEY_LAST]}) begin
			hit = mods[key[2:0]];
		end
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (slots[i] == key) begin
				hit = 1'b1;
			end
		end
		return hit && (key != NO_KEY);
	endfunction

endpackage

// ----- rtl/hkt_front.sv -----
// ----------------------------------------------------------------------------
// hkt_front
// Classifies each accepted report: builds the slot list and marks which
// list entries were not held in the previous keyboard report.
// ----------------------------------------------------------------------------
module hkt_front import hkt_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  report_t report,
	output job_t    job
);

	logic [7:0] prev_mods_q;
	slot_vec_t  prev_slots_q;
	slot_vec_t  slots;
	logic       used;

	always_comb begin
		slots[0] = report.key_slot_0;
		slots[1] = report.key_slot_1;
		slots[2] = report.key_slot_2;
		slots[3] = report.key_slot_3;
		slots[4] = report.key_slot_4;
		slots[5] = report.key_slot_5;
		// slots past the configured count are ignored
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (i >= KEY_SLOTS) begin
				slots[i] = NO_KEY;
			end
		end
		used = (report.dev_type == KBD_REPORT_TYPE);

		job.used      = used;
		job.modifiers = report.modifiers;
		job.slots     = slots;
		for (int i = 0; i < MOD_BITS; i++) begin
			job.push_mask[i] = used && report.modifiers[i] &&
				!key_in_list(MOD_KEY_FIRST + KEY_W'(i), prev_mods_q, prev_slots_q);
		end
		for (int j = 0; j < MAX_SLOTS; j++) begin
			job.push_mask[MOD_BITS+j] = used && (slots[j] != NO_KEY) &&
				!key_in_list(slots[j], prev_mods_q, prev_slots_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q  <= '0;
			prev_slots_q <= '0;
		end else if (accept && used) begin
			prev_mods_q  <= report.modifiers;
			prev_slots_q <= slots;
		end
	end

endmodule

// ----- rtl/hkt_fifo.sv -----
// ----------------------------------------------------------------------------
// hkt_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module hkt_fifo import hkt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic head_valid,
	output logic full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- rtl/hkt_back.sv -----
// ----------------------------------------------------------------------------
// hkt_back
// Recency stack engine: pushes new keys one per cycle, marks released
// entries, then squeezes them out with odd/even neighbor swaps.
// ----------------------------------------------------------------------------
module hkt_back import hkt_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    head,
	input  logic    head_valid,
	output logic    pop,
	output logic    done,
	output result_t result
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SQUEEZE
	} state_t;

	state_t                               state_q;
	logic [STACK_DEPTH-1:0][KEY_W-1:0]    st_q;
	logic [STACK_DEPTH-1:0]               av_q;
	logic [DW-1:0]                        depth_q;
	logic                                 parity_q;
	job_t                                 job_q;
	logic [LIST_LEN-1:0]                  mask_q;
	logic                                 done_q;
	result_t                              result_q;

	key_t                                 pick_key;
	logic [STACK_DEPTH-1:0][KEY_W-1:0]    st_push;
	logic [STACK_DEPTH-1:0]               av_push;
	logic [STACK_DEPTH-1:0]               keep;
	logic [STACK_DEPTH-2:0]               swap;
	logic [STACK_DEPTH-1:0][KEY_W-1:0]    st_sq;
	logic [STACK_DEPTH-1:0]               av_sq;
	logic                                 inversion;
	logic [DW-1:0]                        depth_enc;

	function automatic logic [4:0] sat_count(input logic [DW-1:0] d);
		return (32'(d) > 32'(HELD_COUNT_MAX)) ? HELD_COUNT_MAX : 5'(d);
	endfunction

	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		// lowest pending list entry goes next, so list order is kept
		pick_key = NO_KEY;
		for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
			if (mask_q[MOD_BITS+j]) begin
				pick_key = job_q.slots[j];
			end
		end
		for (int i = MOD_BITS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick_key = MOD_KEY_FIRST + KEY_W'(i);
			end
		end

		// push on top, bottom entry falls off when full
		st_push[0] = pick_key;
		av_push[0] = 1'b1;
		for (int i = 1; i < STACK_DEPTH; i++) begin
			st_push[i] = st_q[i-1];
			av_push[i] = av_q[i-1];
		end

		for (int i = 0; i < STACK_DEPTH; i++) begin
			keep[i] = key_in_list(st_q[i], job_q.modifiers, job_q.slots);
		end

		// a dead entry swaps with a live one below it, pairs alternate by parity
		inversion = 1'b0;
		for (int i = 0; i < STACK_DEPTH - 1; i++) begin
			swap[i]   = (1'(i) == parity_q) && !av_q[i] && av_q[i+1];
			inversion = inversion | (!av_q[i] && av_q[i+1]);
		end
		for (int i = 0; i < STACK_DEPTH; i++) begin
			st_sq[i] = st_q[i];
			av_sq[i] = av_q[i];
			if (i < STACK_DEPTH - 1) begin
				if (swap[i]) begin
					st_sq[i] = st_q[i+1];
					av_sq[i] = av_q[i+1];
				end
			end
			if (i > 0) begin
				if (swap[i-1]) begin
					st_sq[i] = st_q[i-1];
					av_sq[i] = av_q[i-1];
				end
			end
		end

		// live entries form a prefix once squeezed: its end is one-hot
		depth_enc = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (av_q[i] && ((i == STACK_DEPTH - 1) || !av_q[(i+1) % STACK_DEPTH])) begin
				depth_enc = depth_enc | DW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			av_q     <= '0;
			depth_q  <= '0;
			parity_q <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head.used) begin
							state_q <= ST_PUSH;
						end else begin
							done_q               <= 1'b1;
							result_q.top_key     <= av_q[0] ? st_q[0] : NO_KEY;
							result_q.held_count  <= sat_count(depth_q);
							result_q.report_used <= 1'b0;
						end
					end
				end
				ST_PUSH: begin
					if (mask_q != '0) begin
						av_q <= av_push;
					end else begin
						av_q     <= av_q & keep;
						parity_q <= 1'b0;
						state_q  <= ST_SQUEEZE;
					end
				end
				ST_SQUEEZE: begin
					if (inversion) begin
						av_q     <= av_sq;
						parity_q <= ~parity_q;
					end else begin
						depth_q              <= depth_enc;
						done_q               <= 1'b1;
						result_q.top_key     <= av_q[0] ? st_q[0] : NO_KEY;
						result_q.held_count  <= sat_count(depth_enc);
						result_q.report_used <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= head;
			mask_q <= head.push_mask;
		end
		if (state_q == ST_PUSH && mask_q != '0) begin
			st_q   <= st_push;
			mask_q <= mask_q & (mask_q - 1'b1);
		end
		if (state_q == ST_SQUEEZE && inversion) begin
			st_q <= st_sq;
		end
	end

endmodule

// ----- rtl/hid_keyboard_last_key_tracker_top.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_last_key_tracker_top
// Tracks the most recently pressed key still held across boot keyboard
// reports, using a recency stack.
// ----------------------------------------------------------------------------
// usage:
//   a report is taken on a clock edge with start high and busy low. busy is
//   high only while the two-entry job queue is full, so reports may be sent
//   back to back until it fills.
//   each report gives exactly one result, shown for one cycle with done
//   high; results leave in report order and the receiver cannot hold them.
// flow:
//   a report of another device type finishes in the cycle after the back end
//   takes it from the queue. a keyboard report goes through the push state,
//   one stack push per cycle for each newly pressed key (up to 14), then marks
//   released keys, then runs odd/even squeeze passes until the gaps they left
//   are closed (no passes when none, at most STACK_DEPTH passes).
//   the push loop and squeeze passes in the back end set the rate.
// reset:
//   arst_n clears the stack, depth, previous report and the queue; the
//   block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module hid_keyboard_last_key_tracker_top import hkt_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int KEY_SLOTS   = 6
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  report_t report,
	output logic    done,
	output result_t result
);

	logic accept;
	job_t front_job;
	job_t head;
	logic head_valid;
	logic pop;
	logic full;

	assign accept = start && !busy;
	assign busy   = full;

	hkt_front #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.report(report),
		.job   (front_job)
	);

	hkt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_job  (front_job),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid),
		.full      (full)
	);

	hkt_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

	// reported depth never exceeds the stack size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.held_count) <= STACK_DEPTH))
		else $error("held_count above stack depth");

	// an empty stack reports no key
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.held_count == 5'd0) |-> (result.top_key == NO_KEY))
		else $error("top_key nonzero on empty stack");

	// the queue only fills on an accepted item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyboard last-key tracker. Reports go in through
// the start/busy handshake, and a model of the recency stack inside the bench
// predicts the top key, depth and used flag of every result, which are checked
// in order as done pulses. Directed cases come first, then random traffic.
// ----------------------------------------------------------------------------
module testbench;
	import hkt_pkg::*;

	localparam int STACK_SIZE = 16;
	localparam int SLOT_COUNT = 6;

	typedef logic [SLOT_COUNT-1:0][KEY_W-1:0] slot_set_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	report_t report = '0;
	logic    busy;
	logic    done;
	result_t result;

	// tracker model state
	key_t        recent_keys[STACK_SIZE];
	int unsigned recent_count;
	logic [7:0]  held_mods;
	slot_set_t   held_slots;

	result_t expected_key_states[$];
	int      mismatch_count = 0;

	hid_keyboard_last_key_tracker_top #(
		.STACK_DEPTH(STACK_SIZE),
		.KEY_SLOTS(SLOT_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.report(report),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic slot_set_t slots_of(input report_t r);
		return {r.key_slot_5, r.key_slot_4, r.key_slot_3,
			r.key_slot_2, r.key_slot_1, r.key_slot_0};
	endfunction

	function automatic bit is_held(input key_t k, input logic [7:0] mods,
			input slot_set_t slots);
		if (k == NO_KEY) begin
			return 1'b0;
		end
		if (k >= MOD_KEY_FIRST && k <= MOD_KEY_LAST && mods[k[2:0]]) begin
			return 1'b1;
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slots[i] == k) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void push_recent(input key_t k);
		int unsigned n;
		n = recent_count;
		// bottom entry falls off a full stack
		if (n >= STACK_SIZE) begin
			n = STACK_SIZE - 1;
		end
		for (int i = n; i > 0; i--) begin
			recent_keys[i] = recent_keys[i-1];
		end
		recent_keys[0] = k;
		recent_count = n + 1;
	endfunction

	function automatic result_t track_report(input report_t r);
		result_t   res;
		slot_set_t slots;
		key_t      pressed[LIST_LEN];
		int        n;
		int        kept;
		bit        used;
		used = (r.dev_type == KBD_REPORT_TYPE);
		slots = slots_of(r);
		n = 0;
		if (used) begin
			for (int i = 0; i < MOD_BITS; i++) begin
				if (r.modifiers[i]) begin
					pressed[n] = MOD_KEY_FIRST + key_t'(i);
					n++;
				end
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slots[i] != NO_KEY) begin
					pressed[n] = slots[i];
					n++;
				end
			end
			for (int i = 0; i < n; i++) begin
				if (!is_held(pressed[i], held_mods, held_slots)) begin
					push_recent(pressed[i]);
				end
			end
			// stack only holds old or new keys, so keeping those held in this report drops released keys
			kept = 0;
			for (int i = 0; i < recent_count; i++) begin
				if (is_held(recent_keys[i], r.modifiers, slots)) begin
					recent_keys[kept] = recent_keys[i];
					kept++;
				end
			end
			for (int i = kept; i < STACK_SIZE; i++) begin
				recent_keys[i] = NO_KEY;
			end
			recent_count = kept;
			held_mods = r.modifiers;
			held_slots = slots;
		end
		res.top_key = (recent_count != 0) ? recent_keys[0] : NO_KEY;
		res.held_count = (recent_count > HELD_COUNT_MAX) ? HELD_COUNT_MAX : recent_count[4:0];
		res.report_used = used;
		return res;
	endfunction

	function automatic report_t kbd(input logic [7:0] dev, input logic [7:0] mods,
			input key_t s0, input key_t s1, input key_t s2,
			input key_t s3, input key_t s4, input key_t s5);
		report_t r;
		r.dev_type = dev;
		r.modifiers = mods;
		r.key_slot_0 = s0;
		r.key_slot_1 = s1;
		r.key_slot_2 = s2;
		r.key_slot_3 = s3;
		r.key_slot_4 = s4;
		r.key_slot_5 = s5;
		return r;
	endfunction

	function automatic key_t pick_key();
		case ($urandom_range(0, 19))
			0, 1, 2: return MOD_KEY_FIRST + key_t'($urandom_range(0, 7));
			3, 4, 5: return key_t'($urandom_range(1, 255));
			default: return key_t'($urandom_range(4, 15));
		endcase
	endfunction

	// mostly a plausible next report: some keys held, some released, some new
	function automatic report_t next_report(input report_t last);
		report_t   r;
		slot_set_t slots;
		int        pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			return report_t'({$urandom, $urandom});
		end
		r = last;
		if (pick == 1) begin
			r.dev_type = 8'($urandom_range(0, 255));
			return r;
		end
		slots = slots_of(last);
		r.dev_type = KBD_REPORT_TYPE;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			case ($urandom_range(0, 9))
				0, 1: slots[i] = NO_KEY;
				2, 3: slots[i] = pick_key();
				default: ;
			endcase
		end
		if (pick == 2) begin
			r.modifiers = 8'($urandom_range(0, 255));
		end else if ($urandom_range(0, 3) == 0) begin
			r.modifiers = last.modifiers ^ (8'h01 << $urandom_range(0, 7));
		end
		r.key_slot_0 = slots[0];
		r.key_slot_1 = slots[1];
		r.key_slot_2 = slots[2];
		r.key_slot_3 = slots[3];
		r.key_slot_4 = slots[4];
		r.key_slot_5 = slots[5];
		return r;
	endfunction

	task automatic send_report(input report_t r);
		report <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_key_states = {expected_key_states, track_report(r)};
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_key_states.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic log_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch on %s: expected %0h, got %0h", field, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (done === 1'b1) begin
			if (expected_key_states.size() == 0) begin
				log_mismatch("unexpected result", 0, 32'(result));
			end else begin
				want = expected_key_states.pop_front();
				if (result.top_key !== want.top_key) begin
					log_mismatch("top_key", 32'(want.top_key), 32'(result.top_key));
				end
				if (result.held_count !== want.held_count) begin
					log_mismatch("held_count", 32'(want.held_count),
						32'(result.held_count));
				end
				if (result.report_used !== want.report_used) begin
					log_mismatch("report_used", 32'(want.report_used),
						32'(result.report_used));
				end
			end
		end
	end

	task automatic test_ignored_types();
		send_report(kbd(8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
		send_report(kbd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_report(kbd(KBD_REPORT_TYPE, 8'h01, 8'h04, 0, 0, 0, 0, 0));
		send_report(kbd(8'h05, 8'h00, 8'h07, 0, 0, 0, 0, 0));
		send_report(kbd(8'h07, 8'hFF, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_full_chord_and_overflow();
		send_report(kbd(KBD_REPORT_TYPE, 8'hFF, 1, 2, 3, 4, 5, 6));
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 0, 0, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h0F, 1, 2, 3, 4, 5, 6));
		// ten new keys on top of ten held push the held low modifiers off the sixteen-deep stack
		send_report(kbd(KBD_REPORT_TYPE, 8'hFF, 7, 8, 9, 10, 11, 12));
		send_report(kbd(KBD_REPORT_TYPE, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA));
		send_report(kbd(KBD_REPORT_TYPE, 8'h80, 8'hFF, 0, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_repeated_keys();
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 4, 4, 4, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 0, 4, 0, 0, 5, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h01, 8'hE0, 4, 0, 0, 0, 0));
		// modifier code held only through a slot
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 8'hE0, 0, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 0, 0, 0, 8'hE3, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h08, 0, 0, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_drain_pause();
		send_report(kbd(KBD_REPORT_TYPE, 8'h22, 9, 0, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h22, 9, 10, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h02, 0, 10, 11, 0, 0, 0));
		wait_all_results();
		send_report(kbd(8'h01, 8'h00, 0, 0, 0, 0, 0, 0));
		send_report(kbd(KBD_REPORT_TYPE, 8'h00, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic(input int count);
		report_t last;
		bit      idle_on;
		last = kbd(KBD_REPORT_TYPE, 8'h00, 0, 0, 0, 0, 0, 0);
		idle_on = 1'b1;
		for (int i = 0; i < count; i++) begin
			// alternate stretches with and without gaps, none near the end
			if (i % 150 == 0) begin
				idle_on = $urandom_range(0, 2) != 0;
			end
			if (i >= count - 300) begin
				idle_on = 1'b0;
			end
			if (idle_on && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 9));
			end
			last = next_report(last);
			send_report(last);
		end
	endtask

	initial begin
		for (int i = 0; i < STACK_SIZE; i++) begin
			recent_keys[i] = NO_KEY;
		end
		recent_count = 0;
		held_mods = 8'h00;
		held_slots = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_types();
		test_full_chord_and_overflow();
		test_repeated_keys();
		test_drain_pause();
		test_random_traffic(2000);

		wait_all_results();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && expected_key_states.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- hid_keyboard_last_key_tracker_top.f -----
rtl/hkt_pkg.sv
rtl/hkt_front.sv
rtl/hkt_fifo.sv
rtl/hkt_back.sv
rtl/hid_keyboard_last_key_tracker_top.sv
sim/testbench.sv
